>>> hdl/l2cop_pkg.sv
// ----------------------------------------------------------------------------
// L2CAP configuration option parser: shared package
// Option codes, expected lengths, result kinds, parser phases and the
// control-state and result records that pass between the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package l2cop_pkg;

  // Option type codes and the payload lengths that the standard fixes.
  localparam logic [7:0] TYPE_MTU       = 8'd1;
  localparam logic [7:0] TYPE_FLUSH     = 8'd2;
  localparam logic [7:0] TYPE_RETX_FLOW = 8'd4;
  localparam logic [7:0] TYPE_FCS       = 8'd5;

  localparam logic [7:0] LEN_MTU        = 8'd2;
  localparam logic [7:0] LEN_FLUSH      = 8'd2;
  localparam logic [7:0] LEN_RETX_FLOW  = 8'd9;
  localparam logic [7:0] LEN_FCS        = 8'd1;

  // Bit 7 of the type byte marks an option as a hint.
  localparam logic [7:0] HINT_MASK      = 8'h80;

  // Number of payload bytes that are kept for decoding.
  localparam int unsigned PAY_DEPTH     = 9;
  localparam int unsigned PAY_IDX_W     = $clog2(PAY_DEPTH);

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_MTU       = 3'd1,
    KIND_FLUSH     = 3'd2,
    KIND_RETX_FLOW = 3'd3,
    KIND_FCS       = 3'd4,
    KIND_KEPT      = 3'd5,
    KIND_HINT      = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  typedef logic [PAY_DEPTH-1:0][7:0] pay_bytes_t;

  // Parser control state.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_type;
    logic [7:0] held_length;
    logic [7:0] payload_count;
    logic       error_seen;
  } parse_state_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  option_kind;
    logic [7:0]  option_type;
    logic [7:0]  option_length;
    logic [7:0]  flow_mode;
    logic [7:0]  tx_window;
    logic [7:0]  retx_limit;
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic [15:0] word_third;
    logic        status;
    logic        payload_end;
  } result_t;

  // Kind that a type byte decodes to.
  function automatic kind_t opt_kind(input logic [7:0] t);
    kind_t k;
    case (t)
      TYPE_MTU:       k = KIND_MTU;
      TYPE_FLUSH:     k = KIND_FLUSH;
      TYPE_RETX_FLOW: k = KIND_RETX_FLOW;
      TYPE_FCS:       k = KIND_FCS;
      default:        k = ((t & HINT_MASK) != 8'h00) ? KIND_HINT : KIND_KEPT;
    endcase
    return k;
  endfunction

  // Required payload length of a known type; zero for any other type.
  function automatic logic [7:0] opt_need(input logic [7:0] t);
    logic [7:0] n;
    case (t)
      TYPE_MTU:       n = LEN_MTU;
      TYPE_FLUSH:     n = LEN_FLUSH;
      TYPE_RETX_FLOW: n = LEN_RETX_FLOW;
      TYPE_FCS:       n = LEN_FCS;
      default:        n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hdl/l2cop_in_if.sv
// ----------------------------------------------------------------------------
// L2CAP configuration option parser: input channel
// Valid/ready channel that carries one payload byte and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2cop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/l2cop_out_if.sv
// ----------------------------------------------------------------------------
// L2CAP configuration option parser: result channel
// Valid/ready channel that carries one decoded option or error report.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2cop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  option_kind;
  logic [7:0]  option_type;
  logic [7:0]  option_length;
  logic [7:0]  flow_mode;
  logic [7:0]  tx_window;
  logic [7:0]  retx_limit;
  logic [15:0] word_first;
  logic [15:0] word_second;
  logic [15:0] word_third;
  logic        status;
  logic        payload_end;

  modport source (
    output valid, output option_kind, output option_type, output option_length,
    output flow_mode, output tx_window, output retx_limit, output word_first,
    output word_second, output word_third, output status, output payload_end,
    input ready
  );
  modport sink (
    input valid, input option_kind, input option_type, input option_length,
    input flow_mode, input tx_window, input retx_limit, input word_first,
    input word_second, input word_third, input status, input payload_end,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/l2cop_step.sv
// ----------------------------------------------------------------------------
// L2CAP configuration option parser: byte step
// Combinational next-state and result logic for one accepted payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module l2cop_step (
  input  var l2cop_pkg::parse_state_t st,
  input  var l2cop_pkg::pay_bytes_t   pay,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  output l2cop_pkg::parse_state_t     st_nxt,
  output l2cop_pkg::pay_bytes_t       pay_nxt,
  output logic                        res_vld,
  output l2cop_pkg::result_t          res
);

  logic [7:0] need;
  logic [7:0] cnt_inc;

  // Result for a completed option, taken from the type, length and bytes.
  function automatic l2cop_pkg::result_t build_option(
    input logic [7:0]            t,
    input logic [7:0]            len,
    input l2cop_pkg::pay_bytes_t pb,
    input logic                  last
  );
    l2cop_pkg::result_t r;
    l2cop_pkg::kind_t   k;
    r = '0;
    k = l2cop_pkg::opt_kind(t);
    r.option_kind   = k;
    r.option_type   = t;
    r.option_length = len;
    case (k)
      l2cop_pkg::KIND_MTU, l2cop_pkg::KIND_FLUSH: begin
        r.word_first = {pb[1], pb[0]};
      end
      l2cop_pkg::KIND_RETX_FLOW: begin
        r.flow_mode    = pb[0];
        r.tx_window    = pb[1];
        r.retx_limit   = pb[2];
        r.word_first   = {pb[4], pb[3]};
        r.word_second  = {pb[6], pb[5]};
        r.word_third   = {pb[8], pb[7]};
      end
      l2cop_pkg::KIND_FCS: begin
        r.word_first = {8'h00, pb[0]};
      end
      default: begin
      end
    endcase
    r.status      = 1'b0;
    r.payload_end = last;
    return r;
  endfunction

  assign need    = l2cop_pkg::opt_need(st.held_type);
  assign cnt_inc = 8'(st.payload_count + 8'd1);

  // One parse step. An option completion, or an error at the payload end, clears
  // the option context; a malformed option that is not at the end sets the error flag.
  always_comb begin
    st_nxt  = st;
    pay_nxt = pay;
    res_vld = 1'b0;
    res     = '0;

    if (st.error_seen) begin
      if (last_byte) begin
        res_vld         = 1'b1;
        res.status      = 1'b1;
        res.payload_end = 1'b1;
        st_nxt          = '0;
      end
    end else begin
      case (st.phase)
        l2cop_pkg::PH_LEN: begin
          st_nxt.held_length   = data_byte;
          st_nxt.payload_count = 8'd0;
          if (need != 8'd0 && data_byte != need) begin
            res_vld         = 1'b1;
            res.status      = 1'b1;
            res.payload_end = last_byte;
            if (last_byte) begin
              st_nxt = '0;
            end else begin
              st_nxt.error_seen = 1'b1;
            end
          end else if (data_byte == 8'd0) begin
            res_vld = 1'b1;
            res     = build_option(st.held_type, data_byte, pay, last_byte);
            st_nxt  = '0;
          end else if (last_byte) begin
            res_vld         = 1'b1;
            res.status      = 1'b1;
            res.payload_end = 1'b1;
            st_nxt          = '0;
          end else begin
            st_nxt.phase = l2cop_pkg::PH_PAY;
          end
        end

        l2cop_pkg::PH_PAY: begin
          // Only the first bytes of a payload are kept.
          if (st.payload_count < 8'(l2cop_pkg::PAY_DEPTH)) begin
            pay_nxt[st.payload_count[l2cop_pkg::PAY_IDX_W-1:0]] = data_byte;
          end
          st_nxt.payload_count = cnt_inc;
          if (cnt_inc >= st.held_length) begin
            res_vld = 1'b1;
            res     = build_option(st.held_type, st.held_length, pay_nxt, last_byte);
            st_nxt  = '0;
          end else if (last_byte) begin
            res_vld         = 1'b1;
            res.status      = 1'b1;
            res.payload_end = 1'b1;
            st_nxt          = '0;
          end
        end

        default: begin
          // Type byte; an unused phase code is handled the same way.
          st_nxt.phase         = l2cop_pkg::PH_LEN;
          st_nxt.held_type     = data_byte;
          st_nxt.held_length   = 8'd0;
          st_nxt.payload_count = 8'd0;
          if (last_byte) begin
            res_vld         = 1'b1;
            res.status      = 1'b1;
            res.payload_end = 1'b1;
            st_nxt          = '0;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/l2cap_config_option_parser.sv
// ----------------------------------------------------------------------------
// L2CAP configuration option parser: top level
// Parses an L2CAP configuration options payload, one byte per word, into
// decoded option reports and malformed-payload reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one payload byte per word with last_byte set on the final
//   byte of a payload. out_ch carries zero or one report per input word: a
//   decoded option when its last byte arrives, or an error report (status 1)
//   for a known option with the wrong length, or for a payload that ends in
//   the middle of an option. After an error, bytes are swallowed until the
//   last one, which yields a closing error report with payload_end set.
//   A report appears on out_ch in the cycle after the byte that completes it
//   is accepted. Throughput: one byte per cycle unless stalled; the parse
//   step is one layer of logic into the parser state and result register.
//   Stalls: in_ch.ready stays high while the result register is empty or
//   being drained, so a stalled receiver holds back input only while a
//   report waits in the result register.
//   Reset: synchronous, active low; the parser returns to expecting a type
//   byte and the result register empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module l2cap_config_option_parser (
  input wire logic   clk,
  input wire logic   rst_n,
  l2cop_in_if.sink   in_ch,
  l2cop_out_if.source out_ch
);

  l2cop_pkg::parse_state_t st_r;
  l2cop_pkg::parse_state_t st_nxt;
  l2cop_pkg::pay_bytes_t   pay_r;
  l2cop_pkg::pay_bytes_t   pay_nxt;
  l2cop_pkg::result_t      out_r;
  l2cop_pkg::result_t      res;
  logic                    out_valid_r;
  logic                    res_vld;
  logic                    in_fire;
  logic                    out_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // Next state and result for the byte on the input channel.
  l2cop_step u_step (
    .st        (st_r),
    .pay       (pay_r),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .st_nxt    (st_nxt),
    .pay_nxt   (pay_nxt),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Parser control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Kept payload bytes; only bytes of the current option are ever read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pay_r <= pay_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_vld;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.option_kind   = out_r.option_kind;
  assign out_ch.option_type   = out_r.option_type;
  assign out_ch.option_length = out_r.option_length;
  assign out_ch.flow_mode     = out_r.flow_mode;
  assign out_ch.tx_window     = out_r.tx_window;
  assign out_ch.retx_limit    = out_r.retx_limit;
  assign out_ch.word_first    = out_r.word_first;
  assign out_ch.word_second   = out_r.word_second;
  assign out_ch.word_third    = out_r.word_third;
  assign out_ch.status        = out_r.status;
  assign out_ch.payload_end   = out_r.payload_end;

`ifndef ASSERT_OFF
  // An error report carries no option kind.
  a_err_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> out_r.option_kind == l2cop_pkg::KIND_NONE)
    else $error("error report carries an option kind");

  // A good report always names a kind.
  a_ok_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.status |-> out_r.option_kind != l2cop_pkg::KIND_NONE)
    else $error("good report without option kind");

  // The last byte of a payload always leaves the parser fresh.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.last_byte |=> st_r.phase == l2cop_pkg::PH_TYPE && !st_r.error_seen)
    else $error("parser not cleared after last byte");

  // Inside a payload the byte count stays below the option length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == l2cop_pkg::PH_PAY |-> st_r.payload_count < st_r.held_length)
    else $error("payload count reached option length");
`endif

endmodule

`default_nettype wire
